[design/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

  // Fractional bits of the unsigned fixed-point intermediates.
  localparam int FRAC_BITS = 16;
  // A fraction ranges over 0..1.0 inclusive, so it needs one more bit.
  localparam int Q_W = FRAC_BITS + 1;
  // Width of the triangle weight k, 0..60.
  localparam int K_W = 6;
  // Width of c * k.
  localparam int P_W = Q_W + K_W;

  localparam logic [8:0] HUE_MAX    = 9'd360;
  localparam logic [6:0] SECTOR_DEG = 7'd60;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  // Division by 60 uses a rounded-up reciprocal. The rounding error of the
  // reciprocal is below 64, so six guard bits keep the quotient exact for
  // every product below 2**P_W.
  localparam int RECIP_SHIFT = P_W + 6;
  localparam int R_W = RECIP_SHIFT - 5;
  localparam logic [R_W-1:0] RECIP =
    R_W'(((64'd1 << RECIP_SHIFT) + 64'(SECTOR_DEG) - 64'd1) / 64'(SECTOR_DEG));
  localparam int XP_W = P_W + R_W;

  // Division of a byte fraction by 255 also uses a rounded-up reciprocal.
  // The numerator is below 2**(FRAC_BITS+8) and the rounding error below
  // 2**8, so sixteen guard bits keep the quotient exact.
  localparam int BYTE_GUARD = 16;
  localparam int BYTE_SHIFT = FRAC_BITS + BYTE_GUARD;
  localparam int BR_W = FRAC_BITS + 9;
  localparam logic [BR_W-1:0] BYTE_RECIP =
    BR_W'(((64'd1 << BYTE_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

  // 60-degree sectors of the hue circle, red to yellow first.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

  // After decode: sector, weight and the two fractions.
  typedef struct packed {
    sector_t        sector;
    logic [K_W-1:0] k;
    logic [Q_W-1:0] s_q;
    logic [Q_W-1:0] v_q;
  } dec_beat_t;

  // After the chroma multiply.
  typedef struct packed {
    sector_t        sector;
    logic [K_W-1:0] k;
    logic [Q_W-1:0] c;
    logic [Q_W-1:0] v_q;
  } chr_beat_t;

  // After the weight multiply and the offset subtraction.
  typedef struct packed {
    sector_t        sector;
    logic [Q_W-1:0] c;
    logic [Q_W-1:0] m;
    logic [P_W-1:0] ck;
  } wgt_beat_t;

  // An 8-bit fraction scaled so that 255 maps exactly to 1.0. The factor
  // 2**FRAC_BITS of the numerator cancels against the reciprocal's shift.
  function automatic logic [Q_W-1:0] frac_of_byte(input logic [7:0] b);
    logic [BR_W+7:0] w;
    w = {{BR_W{1'b0}}, b} * {8'd0, BYTE_RECIP};
    return w[BYTE_GUARD +: Q_W];
  endfunction

endpackage

[design/hsv_to_rgb_converter.sv]
// HSV to RGB pixel converter.
//
// Input channel: in_valid, in_stall (driven by this block) and in_data, a beat
// carrying hue in degrees (values above 360 are treated as 360) and
// saturation and brightness as 8-bit fractions where 255 stands for 1.0.
// Output channel: out_valid, out_stall (driven by the receiver) and out_data,
// a beat carrying the red, green and blue channels, 0..255, truncated.
//
// The datapath is a five-stage pipeline: decode, chroma multiply, weight
// multiply, reciprocal multiply for the division by 60, and the channel
// scaling into the output register. An accepted beat passes through these
// stage registers in order and then shows on out_valid.
// One beat is accepted in every cycle in which in_stall is low; each
// multiplier stage is the depth that sets the clock.
// The whole pipeline advances together. When the output holds a beat that
// the receiver stalls, every stage freezes and in_stall rises in the same
// cycle, so no beat is lost or repeated; bubbles are filled as soon as the
// output moves on. Reset clears all valid bits; no beat is in flight after it.
module hsv_to_rgb_converter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hsv2rgb_pkg::hsv_pix_t in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hsv2rgb_pkg::rgb_pix_t out_data
);
  import hsv2rgb_pkg::*;

  // Pipeline advance: the output register is empty or its beat is taken.
  logic      en;
  logic      dec_vld;
  dec_beat_t dec_beat;
  logic      wgt_vld;
  wgt_beat_t wgt_beat;
  logic      in_acc;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign in_acc   = in_valid && !in_stall;

  hsv2rgb_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_pix   (in_data),
    .out_vld  (dec_vld),
    .out_beat (dec_beat)
  );

  hsv2rgb_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dec_vld),
    .in_beat  (dec_beat),
    .out_vld  (wgt_vld),
    .out_beat (wgt_beat)
  );

  hsv2rgb_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (wgt_vld),
    .in_beat  (wgt_beat),
    .out_vld  (out_valid),
    .out_pix  (out_data)
  );

  // An accepted beat is on the output once the pipeline has advanced it
  // through every stage register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 en [*4] |=> out_valid)
    else $error("accepted beat did not reach the output on time");

  // A frozen pipeline keeps the valid bits of the decode, weight and output stages.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dec_vld) && $stable(wgt_vld) && $stable(out_valid))
    else $error("pipeline moved while stalled");

  // The offset and chroma of a beat in flight never exceed full scale.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    wgt_vld |-> ({1'b0, wgt_beat.c} + {1'b0, wgt_beat.m}) <= (Q_W + 1)'(1 << FRAC_BITS))
    else $error("chroma plus offset above one");

endmodule

[design/hsv2rgb_decode.sv]
module hsv2rgb_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  hsv2rgb_pkg::hsv_pix_t in_pix,
  output logic                  out_vld,
  output hsv2rgb_pkg::dec_beat_t out_beat
);
  import hsv2rgb_pkg::*;

  localparam logic [8:0] B1 = 9'(SECTOR_DEG);
  localparam logic [8:0] B2 = 9'(2 * SECTOR_DEG);
  localparam logic [8:0] B3 = 9'(3 * SECTOR_DEG);
  localparam logic [8:0] B4 = 9'(4 * SECTOR_DEG);
  localparam logic [8:0] B5 = 9'(5 * SECTOR_DEG);
  localparam logic [8:0] B6 = 9'(6 * SECTOR_DEG);
  localparam logic [6:0] TWO_SEC = 7'(2 * SECTOR_DEG);

  logic       vld_r;
  dec_beat_t  beat_r, beat_nxt;
  logic [8:0] hue_c;
  logic [8:0] t9;
  logic [6:0] t;
  logic [6:0] k7;

  always_comb begin
    hue_c = (in_pix.hue > HUE_MAX) ? HUE_MAX : in_pix.hue;

    priority if (hue_c < B1) beat_nxt.sector = SEC_RED_YEL;
    else if (hue_c < B2)     beat_nxt.sector = SEC_YEL_GRN;
    else if (hue_c < B3)     beat_nxt.sector = SEC_GRN_CYN;
    else if (hue_c < B4)     beat_nxt.sector = SEC_CYN_BLU;
    else if (hue_c < B5)     beat_nxt.sector = SEC_BLU_MAG;
    else                     beat_nxt.sector = SEC_MAG_RED;

    // Position inside the 120-degree period of the triangle wave.
    priority if (hue_c >= B6) t9 = hue_c - B6;
    else if (hue_c >= B4)     t9 = hue_c - B4;
    else if (hue_c >= B2)     t9 = hue_c - B2;
    else                      t9 = hue_c;
    t  = t9[6:0];
    k7 = (t >= SECTOR_DEG) ? (TWO_SEC - t) : t;

    beat_nxt.k   = k7[K_W-1:0];
    beat_nxt.s_q = frac_of_byte(in_pix.saturation);
    beat_nxt.v_q = frac_of_byte(in_pix.brightness);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_beat = beat_r;

endmodule

[design/hsv2rgb_chroma.sv]
module hsv2rgb_chroma (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  hsv2rgb_pkg::dec_beat_t in_beat,
  output logic                   out_vld,
  output hsv2rgb_pkg::wgt_beat_t out_beat
);
  import hsv2rgb_pkg::*;

  logic             chr_vld_r;
  chr_beat_t        chr_r, chr_nxt;
  logic [2*Q_W-1:0] vs;
  logic             wgt_vld_r;
  wgt_beat_t        wgt_r, wgt_nxt;

  // First stage: chroma c = v * s.
  always_comb begin
    vs             = {{Q_W{1'b0}}, in_beat.v_q} * {{Q_W{1'b0}}, in_beat.s_q};
    chr_nxt.sector = in_beat.sector;
    chr_nxt.k      = in_beat.k;
    chr_nxt.c      = vs[FRAC_BITS +: Q_W];
    chr_nxt.v_q    = in_beat.v_q;
  end

  // Second stage: c * k ahead of the division by 60, and the offset m.
  always_comb begin
    wgt_nxt.sector = chr_r.sector;
    wgt_nxt.c      = chr_r.c;
    wgt_nxt.m      = chr_r.v_q - chr_r.c;
    wgt_nxt.ck     = {{K_W{1'b0}}, chr_r.c} * {{Q_W{1'b0}}, chr_r.k};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_vld_r <= 1'b0;
      wgt_vld_r <= 1'b0;
    end else if (en) begin
      chr_vld_r <= in_vld;
      wgt_vld_r <= chr_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chr_r <= chr_nxt;
      wgt_r <= wgt_nxt;
    end
  end

  assign out_vld  = wgt_vld_r;
  assign out_beat = wgt_r;

endmodule

[design/hsv2rgb_mix.sv]
module hsv2rgb_mix (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  hsv2rgb_pkg::wgt_beat_t in_beat,
  output logic                   out_vld,
  output hsv2rgb_pkg::rgb_pix_t  out_pix
);
  import hsv2rgb_pkg::*;

  logic            quo_vld_r;
  sector_t         sector_r;
  logic [Q_W-1:0]  c_r;
  logic [Q_W-1:0]  m_r;
  logic [XP_W-1:0] xp_r, xp_nxt;
  logic            pix_vld_r;
  rgb_pix_t        pix_r, pix_nxt;
  logic [Q_W-1:0]  x;
  logic [Q_W-1:0]  r_q, g_q, b_q;
  logic [Q_W+7:0]  r_s, g_s, b_s;

  // Reciprocal multiply: the quotient by 60 sits above RECIP_SHIFT.
  assign xp_nxt = {{R_W{1'b0}}, in_beat.ck} * {{P_W{1'b0}}, RECIP};

  always_comb begin
    x   = xp_r[RECIP_SHIFT +: Q_W];
    r_q = '0;
    g_q = '0;
    b_q = '0;
    unique case (sector_r)
      SEC_RED_YEL: begin r_q = c_r; g_q = x;   end
      SEC_YEL_GRN: begin r_q = x;   g_q = c_r; end
      SEC_GRN_CYN: begin g_q = c_r; b_q = x;   end
      SEC_CYN_BLU: begin g_q = x;   b_q = c_r; end
      SEC_BLU_MAG: begin r_q = x;   b_q = c_r; end
      SEC_MAG_RED: begin r_q = c_r; b_q = x;   end
      default:     begin r_q = '0;  g_q = '0;  end
    endcase
    // Each sum stays at or below v, so the scaled value never exceeds 255.
    r_s = {8'd0, r_q + m_r} * {{Q_W{1'b0}}, FULL_SCALE};
    g_s = {8'd0, g_q + m_r} * {{Q_W{1'b0}}, FULL_SCALE};
    b_s = {8'd0, b_q + m_r} * {{Q_W{1'b0}}, FULL_SCALE};
    pix_nxt.red   = r_s[FRAC_BITS +: 8];
    pix_nxt.green = g_s[FRAC_BITS +: 8];
    pix_nxt.blue  = b_s[FRAC_BITS +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_vld_r <= 1'b0;
      pix_vld_r <= 1'b0;
    end else if (en) begin
      quo_vld_r <= in_vld;
      pix_vld_r <= quo_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector_r <= in_beat.sector;
      c_r      <= in_beat.c;
      m_r      <= in_beat.m;
      xp_r     <= xp_nxt;
      pix_r    <= pix_nxt;
    end
  end

  assign out_vld = pix_vld_r;
  assign out_pix = pix_r;

endmodule
